@@ hdl/bpc_pkg.sv @@
package bpc_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_TRIM_SIGNED_A    = 3'd0;
  localparam logic [2:0] REG_TRIM_UNSIGNED_A  = 3'd1;
  localparam logic [2:0] REG_TRIM_QUADRATIC   = 3'd2;
  localparam logic [2:0] REG_TRIM_TEMP_CURVE  = 3'd3;
  localparam logic [2:0] REG_OVERSAMPLING     = 3'd4;

  localparam int DIV_W      = 32;
  localparam int DIV_SIDE_W = 53;

  localparam logic [31:0] K_B6_OFFSET = 32'd4000;
  localparam logic [31:0] K_P_SQ      = 32'd3038;
  localparam logic [31:0] K_P_LIN     = 32'hFFFF_E343; // -7357
  localparam logic [31:0] K_P_OFF     = 32'd3791;
  localparam logic [31:0] K_B7_SCALE  = 32'd50000;
  localparam logic [31:0] K_HALF      = 32'd32768;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr32(logic [31:0] v, int s);
    return 32'($signed(v) >>> s);
  endfunction

endpackage

@@ hdl/bpc_div.sv @@
// Unsigned 32/32 restoring divider, one quotient bit per pipeline stage.
module bpc_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [31:0]                    n_i,
  input  logic [31:0]                    d_i,
  input  logic [bpc_pkg::DIV_SIDE_W-1:0] side_i,
  output logic                           valid_o,
  output logic [31:0]                    q_o,
  output logic [bpc_pkg::DIV_SIDE_W-1:0] side_o
);
  import bpc_pkg::*;

  logic [DIV_W-1:0]      r_s    [0:DIV_W];
  logic [DIV_W-1:0]      n_s    [0:DIV_W];
  logic [DIV_W-1:0]      d_s    [0:DIV_W];
  logic [DIV_W-1:0]      q_s    [0:DIV_W];
  logic [DIV_SIDE_W-1:0] side_s [0:DIV_W];
  logic                  v_s    [0:DIV_W];

  assign r_s[0]    = '0;
  assign n_s[0]    = n_i;
  assign d_s[0]    = d_i;
  assign q_s[0]    = '0;
  assign side_s[0] = side_i;
  assign v_s[0]    = valid_i;

  for (genvar s = 0; s < DIV_W; s++) begin : g_stage
    logic [DIV_W:0] trial;
    logic           fits;
    assign trial = {r_s[s], n_s[s][DIV_W-1]};
    assign fits  = trial >= {1'b0, d_s[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[s+1] <= 1'b0;
      end else if (en_i) begin
        v_s[s+1] <= v_s[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_s[s+1]    <= fits ? DIV_W'(trial - {1'b0, d_s[s]}) : trial[DIV_W-1:0];
        n_s[s+1]    <= {n_s[s][DIV_W-2:0], 1'b0};
        d_s[s+1]    <= d_s[s];
        q_s[s+1]    <= {q_s[s][DIV_W-2:0], fits};
        side_s[s+1] <= side_s[s];
      end
    end
  end

  assign valid_o = v_s[DIV_W];
  assign q_o     = q_s[DIV_W];
  assign side_o  = side_s[DIV_W];

endmodule

@@ hdl/baro_pressure_temperature_compensate_unit.sv @@
// Barometric pressure/temperature compensation pipeline.
// Input channel: one transaction carries a raw temperature word and a raw
// pressure word (in_valid_i / in_ready_o). Output channel: one transaction
// per input, carrying temperature in 0.1 degC, pressure in Pa and a flag
// set when a divisor was zero (out_valid_o / out_ready_i).
// Config channel: cfg_index_i selects a calibration register, cfg_data_i
// is written when cfg_valid_i is high; cfg_ready_o is always high. Write
// only while the pipe is empty.
// Throughput: one transaction per cycle while the output is not stalled.
// From input acceptance to the output register the pipe runs through the
// two 32-stage bit-per-stage dividers plus the P1..P13 stages.
// Reset clears all valid bits and the calibration registers to zero.
// When the receiver stalls with a result waiting, the whole pipe freezes;
// nothing is dropped or repeated, and in_ready_o falls for that time.
module baro_pressure_temperature_compensate_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] raw_temperature_i,
  input  logic [18:0] raw_pressure_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] temperature_tenths_o,
  output logic signed [31:0] pressure_pascal_o,
  output logic        divide_error_o
);
  import bpc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [47:0] trim_sa_q, trim_ua_q;
  logic [31:0] trim_quad_q, trim_curve_q;
  logic [1:0]  os_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_sa_q    <= '0;
      trim_ua_q    <= '0;
      trim_quad_q  <= '0;
      trim_curve_q <= '0;
      os_q         <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_TRIM_SIGNED_A:   trim_sa_q    <= cfg_data_i;
        REG_TRIM_UNSIGNED_A: trim_ua_q    <= cfg_data_i;
        REG_TRIM_QUADRATIC:  trim_quad_q  <= cfg_data_i[31:0];
        REG_TRIM_TEMP_CURVE: trim_curve_q <= cfg_data_i[31:0];
        REG_OVERSAMPLING:    os_q         <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // unpacked calibration words, all 32-bit
  logic [31:0] c1, c2, c3, scale, tgain, toff, qb4, qb3, num, den;
  assign c1    = sx16(trim_sa_q[47:32]);
  assign c2    = sx16(trim_sa_q[31:16]);
  assign c3    = sx16(trim_sa_q[15:0]);
  assign scale = {16'd0, trim_ua_q[47:32]};
  assign tgain = {16'd0, trim_ua_q[31:16]};
  assign toff  = {16'd0, trim_ua_q[15:0]};
  assign qb4   = sx16(trim_quad_q[31:16]);
  assign qb3   = sx16(trim_quad_q[15:0]);
  assign num   = sx16(trim_curve_q[31:16]);
  assign den   = sx16(trim_curve_q[15:0]);

  // global advance: whole pipe moves unless a result is stuck at the output
  logic adv;
  logic out_v_q;
  assign adv        = !out_v_q || out_ready_i;
  assign in_ready_o = adv;

  // ---------------- P1: temperature gain product ----------------
  logic        v1_q;
  logic [31:0] prod1_q;
  logic [18:0] up1_q;

  // ---------------- P2: divisor prep ----------------
  logic        v2_q;
  logic [31:0] a2_q, mn2_q, md2_q;
  logic        neg2_q, z2_q;
  logic [18:0] up2_q;

  logic [31:0] a2_d, dv2_d, n2_d;
  assign a2_d  = asr32(prod1_q, 15);
  assign dv2_d = a2_d + den;
  assign n2_d  = num << 11;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod1_q <= (({16'd0, raw_temperature_i}) - toff) * tgain;
      up1_q   <= raw_pressure_i;
      a2_q    <= a2_d;
      mn2_q   <= n2_d[31] ? 32'(0 - n2_d) : n2_d;
      md2_q   <= dv2_d[31] ? 32'(0 - dv2_d) : dv2_d;
      neg2_q  <= n2_d[31] ^ dv2_d[31];
      z2_q    <= dv2_d == '0;
      up2_q   <= up1_q;
    end
  end

  // ---------------- temperature divider ----------------
  logic                  dv1_v;
  logic [31:0]           dv1_q;
  logic [DIV_SIDE_W-1:0] dv1_side;

  bpc_div u_div_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v2_q),
    .n_i     (mn2_q),
    .d_i     (md2_q),
    .side_i  ({a2_q, up2_q, neg2_q, z2_q}),
    .valid_o (dv1_v),
    .q_o     (dv1_q),
    .side_o  (dv1_side)
  );

  logic [31:0] a3_in;
  logic [18:0] up3_in;
  logic        neg3_in, z3_in;
  assign {a3_in, up3_in, neg3_in, z3_in} = dv1_side;

  // ---------------- P3: temperature result, b6 ----------------
  logic        v3_q, z3_q;
  logic [31:0] b6_3_q;
  logic [15:0] t3_q;
  logic [18:0] up3_q;
  logic [31:0] tb3_d, t3_full;
  assign tb3_d   = a3_in + (neg3_in ? 32'(0 - dv1_q) : dv1_q);
  assign t3_full = asr32(tb3_d + 32'd8, 4);

  // ---------------- P4..P9 ----------------
  logic        v4_q, z4_q, v5_q, z5_q, v6_q, z6_q, v7_q, z7_q, v8_q, z8_q, v9_q;
  logic [15:0] t4_q, t5_q, t6_q, t7_q, t8_q, t9_q;
  logic [18:0] up4_q, up5_q, up6_q;
  logic [31:0] sq4_q, c2b6_q, c3b6_q;
  logic [31:0] x5_q, y5_q, bb5_q, aa5_q;
  logic [31:0] lin6_q, half6_q;
  logic [31:0] k7_q, diff7_q;
  logic [31:0] k8_q, b7_8_q;
  logic [31:0] n9_q, k9_q;
  logic [DIV_SIDE_W-1:0] side9_q;

  logic [31:0] c6_d, l6_d, c4_6_d, kp7_d;
  assign c6_d   = asr32(asr32(x5_q, 12), 11) + bb5_q;
  assign l6_d   = asr32(((c1 << 2) + c6_d) << os_q, 0) + 32'd2;
  assign c4_6_d = asr32(aa5_q + asr32(y5_q, 16) + 32'd2, 2);
  assign kp7_d  = scale * half6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else if (adv) begin
      v3_q <= dv1_v;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // P3
      z3_q    <= z3_in;
      b6_3_q  <= tb3_d - K_B6_OFFSET;
      t3_q    <= t3_full[15:0];
      up3_q   <= up3_in;
      // P4: square and linear products
      z4_q    <= z3_q;
      t4_q    <= t3_q;
      up4_q   <= up3_q;
      sq4_q   <= b6_3_q * b6_3_q;
      c2b6_q  <= c2 * b6_3_q;
      c3b6_q  <= c3 * b6_3_q;
      // P5: quadratic products
      z5_q    <= z4_q;
      t5_q    <= t4_q;
      up5_q   <= up4_q;
      x5_q    <= qb3 * sq4_q;
      y5_q    <= qb4 * asr32(sq4_q, 12);
      bb5_q   <= asr32(c2b6_q, 11);
      aa5_q   <= asr32(c3b6_q, 13);
      // P6: offset and scale terms
      z6_q    <= z5_q;
      t6_q    <= t5_q;
      up6_q   <= up5_q;
      lin6_q  <= asr32(l6_d, 2);
      half6_q <= c4_6_d + K_HALF;
      // P7: k4 and pressure difference
      z7_q    <= z6_q;
      t7_q    <= t6_q;
      k7_q    <= kp7_d >> 15;
      diff7_q <= {13'd0, up6_q} - lin6_q;
      // P8: b7
      z8_q    <= z7_q;
      t8_q    <= t7_q;
      k8_q    <= k7_q;
      b7_8_q  <= diff7_q * (K_B7_SCALE >> os_q);
      // P9: dividend select
      t9_q    <= t8_q;
      n9_q    <= b7_8_q[31] ? b7_8_q : {b7_8_q[30:0], 1'b0};
      k9_q    <= k8_q;
      side9_q <= DIV_SIDE_W'({t8_q, z8_q, k8_q == '0, b7_8_q[31]});
    end
  end

  // ---------------- pressure divider ----------------
  logic                  dv2_v;
  logic [31:0]           dv2_q;
  logic [DIV_SIDE_W-1:0] dv2_side;

  bpc_div u_div_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v9_q),
    .n_i     (n9_q),
    .d_i     (k9_q),
    .side_i  (side9_q),
    .valid_o (dv2_v),
    .q_o     (dv2_q),
    .side_o  (dv2_side)
  );

  logic [15:0] t10_in;
  logic        z10_in, kz10_in, big10_in;
  assign {t10_in, z10_in, kz10_in, big10_in} = dv2_side[18:0];

  // ---------------- P10..P13: pressure polynomial ----------------
  logic        v10_q, v11_q, v12_q;
  logic [15:0] t10_q, t11_q, t12_q;
  logic [1:0]  e10_q, e11_q, e12_q; // {temp divisor zero, pressure divisor zero}
  logic [31:0] p10_q, a10_q, p11_q, a11_q, bm11_q, p12_q, a12_q, bm12_q;
  logic [31:0] p10_d, p13_d;

  assign p10_d = big10_in ? {dv2_q[30:0], 1'b0} : dv2_q;
  assign p13_d = p12_q + asr32(asr32(a12_q, 16) + bm12_q + K_P_OFF, 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q   <= 1'b0;
      v11_q   <= 1'b0;
      v12_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      v10_q   <= dv2_v;
      v11_q   <= v10_q;
      v12_q   <= v11_q;
      out_v_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t10_q  <= t10_in;
      e10_q  <= {z10_in, kz10_in};
      p10_q  <= p10_d;
      a10_q  <= asr32(p10_d, 8);
      t11_q  <= t10_q;
      e11_q  <= e10_q;
      p11_q  <= p10_q;
      a11_q  <= a10_q * a10_q;
      bm11_q <= K_P_LIN * p10_q;
      t12_q  <= t11_q;
      e12_q  <= e11_q;
      p12_q  <= p11_q;
      a12_q  <= a11_q * K_P_SQ;
      bm12_q <= asr32(bm11_q, 16);
      // output register
      if (e12_q[1]) begin
        temperature_tenths_o <= '0;
        pressure_pascal_o    <= '0;
        divide_error_o       <= 1'b1;
      end else if (e12_q[0]) begin
        temperature_tenths_o <= t12_q;
        pressure_pascal_o    <= '0;
        divide_error_o       <= 1'b1;
      end else begin
        temperature_tenths_o <= t12_q;
        pressure_pascal_o    <= p13_d;
        divide_error_o       <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_v_q;

endmodule

@@ tb/testbench.sv @@
// Testbench for baro_pressure_temperature_compensate_unit.
// A queue of raw sample pairs feeds a clocked driver; a clocked monitor
// checks every result against a behavioral predictor that runs at input
// acceptance with its own copy of the calibration registers.
module testbench;
  import bpc_pkg::*;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [18:0] raw_press;
  } sample_t;

  typedef struct packed {
    logic [15:0] temp_tenths;
    logic [31:0] press_pa;
    logic        div_err;
  } reading_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] raw_temperature_i = '0;
  logic [18:0] raw_pressure_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [15:0] temperature_tenths_o;
  logic signed [31:0] pressure_pascal_o;
  logic        divide_error_o;

  // calibration copy used by the predictor
  logic [47:0] cal_signed_a = '0;
  logic [47:0] cal_unsigned_a = '0;
  logic [31:0] cal_quadratic = '0;
  logic [31:0] cal_temp_curve = '0;
  logic [1:0]  cal_oversampling = '0;

  sample_t  samples_pending[$];
  reading_t readings_due[$];
  int       mismatch_count = 0;
  int       sender_idle_pct = 0;
  int       receiver_stall_pct = 0;

  baro_pressure_temperature_compensate_unit i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [31:0] shr_signed(logic [31:0] v, int s);
    logic signed [31:0] sv;
    sv = v;
    return sv >>> s;
  endfunction

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // signed divide truncating toward zero, done on magnitudes so that
  // -2^31 / -1 wraps the way 32-bit hardware does
  function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
    logic [31:0] mag_n, mag_d, q;
    mag_n = n[31] ? -n : n;
    mag_d = d[31] ? -d : d;
    q = mag_n / mag_d;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  function automatic reading_t compensate(sample_t s);
    logic [31:0] c1, c2, c3, scale, tgain, toff, qb4, qb3, num, den;
    logic [31:0] ut, up, a, b, c, divisor, tb, b6, sq, lin3, k4, b7, p, t;
    int os;
    reading_t r;
    c1 = sext16(cal_signed_a[47:32]);
    c2 = sext16(cal_signed_a[31:16]);
    c3 = sext16(cal_signed_a[15:0]);
    scale = {16'd0, cal_unsigned_a[47:32]};
    tgain = {16'd0, cal_unsigned_a[31:16]};
    toff  = {16'd0, cal_unsigned_a[15:0]};
    qb4 = sext16(cal_quadratic[31:16]);
    qb3 = sext16(cal_quadratic[15:0]);
    num = sext16(cal_temp_curve[31:16]);
    den = sext16(cal_temp_curve[15:0]);
    os = cal_oversampling;
    ut = {16'd0, s.raw_temp};
    up = {13'd0, s.raw_press};
    r = '0;

    // temperature
    a = shr_signed((ut - toff) * tgain, 15);
    divisor = a + den;
    if (divisor == 0) begin
      r.div_err = 1'b1;       // temperature divisor zero kills both results
      return r;
    end
    b = div_trunc(num << 11, divisor);
    tb = a + b;
    t = shr_signed(tb + 32'd8, 4);
    r.temp_tenths = t[15:0];

    // pressure coefficients
    b6 = tb - K_B6_OFFSET;
    sq = b6 * b6;
    a = shr_signed(shr_signed(qb3 * sq, 12), 11);
    b = shr_signed(c2 * b6, 11);
    c = a + b;
    lin3 = shr_signed(((c1 * 32'd4 + c) << os) + 32'd2, 2);
    a = shr_signed(c3 * b6, 13);
    b = shr_signed(qb4 * shr_signed(sq, 12), 16);
    c = shr_signed(a + b + 32'd2, 2);
    k4 = (scale * (c + K_HALF)) >> 15;
    if (k4 == 0) begin
      r.div_err = 1'b1;       // pressure divisor zero, temperature kept
      return r;
    end

    b7 = (up - lin3) * (K_B7_SCALE >> os);
    if (b7 < 32'h8000_0000) p = (b7 << 1) / k4;
    else p = (b7 / k4) << 1;
    a = shr_signed(p, 8);
    a = a * a;
    a = shr_signed(a * K_P_SQ, 16);
    b = shr_signed(K_P_LIN * p, 16);
    p = p + shr_signed(a + b + K_P_OFF, 4);
    r.press_pa = p;
    return r;
  endfunction

  // driver: a new sample is presented only once the previous transaction
  // is gone, so valid and payload stay put while the block holds off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        readings_due.push_back(compensate({raw_temperature_i, raw_pressure_i}));
      if (!(in_valid_i && !in_ready_o)) begin
        if (samples_pending.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
          sample_t s;
          s = samples_pending.pop_front();
          raw_temperature_i <= s.raw_temp;
          raw_pressure_i <= s.raw_press;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result with the oldest pending reading
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        reading_t got, want;
        got = {temperature_tenths_o, pressure_pascal_o, divide_error_o};
        if (readings_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: temp %0d press %0d err %0b",
                     $signed(got.temp_tenths), $signed(got.press_pa), got.div_err);
        end else begin
          want = readings_due.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: temp %0d/%0d press %0d/%0d err %0b/%0b (exp/act)",
                       $signed(want.temp_tenths), $signed(got.temp_tenths),
                       $signed(want.press_pa), $signed(got.press_pa),
                       want.div_err, got.div_err);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // one register write transaction; valid is left high for a following one
  task automatic write_reg(logic [2:0] idx, logic [47:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TRIM_SIGNED_A:   cal_signed_a = data;
      REG_TRIM_UNSIGNED_A: cal_unsigned_a = data;
      REG_TRIM_QUADRATIC:  cal_quadratic = data[31:0];
      REG_TRIM_TEMP_CURVE: cal_temp_curve = data[31:0];
      REG_OVERSAMPLING:    cal_oversampling = data[1:0];
      default: ;           // out-of-list index is ignored
    endcase
  endtask

  task automatic load_calibration(logic [47:0] sa, logic [47:0] ua, logic [31:0] q,
                                  logic [31:0] tc, logic [1:0] os);
    write_reg(REG_TRIM_SIGNED_A, sa);
    write_reg(REG_TRIM_UNSIGNED_A, ua);
    write_reg(REG_TRIM_QUADRATIC, {16'($urandom()), q});  // upper bits dropped
    write_reg(REG_TRIM_TEMP_CURVE, {16'hFFFF, tc});
    write_reg(REG_OVERSAMPLING, {46'({$urandom(), $urandom()}), os});
    write_reg(3'd5 + 3'($urandom_range(2)), 48'({$urandom(), $urandom()}));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    while (samples_pending.size() != 0 || in_valid_i || readings_due.size() != 0)
      @(posedge clk_i);
    repeat (90) @(posedge clk_i);   // pipe is 77 deep
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      sample_t s;
      case ($urandom_range(9))
        0: s = {16'hFFFF, 19'h7FFFF};
        1: s = {16'h0000, 19'h00000};
        2: s = {16'($urandom()), 19'($urandom())};
        default: s = {16'($urandom_range(33000, 24000)),
                      19'($urandom_range(100000, 20000) << cal_oversampling)};
      endcase
      samples_pending.push_back(s);
    end
  endtask

  // typical factory calibration
  localparam logic [47:0] TYP_SA = {16'd408, 16'hFFB8, 16'hC7D1};
  localparam logic [47:0] TYP_UA = {16'd32741, 16'd32757, 16'd23153};
  localparam logic [31:0] TYP_Q  = {16'd6190, 16'd4};
  localparam logic [31:0] TYP_TC = {16'hDDF9, 16'd2868};

  initial begin
    int phase;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset calibration: temperature divisor is zero for every sample
    samples_pending.push_back({16'h0000, 19'h00000});
    samples_pending.push_back({16'hFFFF, 19'h7FFFF});
    samples_pending.push_back({16'h8000, 19'h40000});
    drain();

    // directed: typical trim, every oversampling, extremes of inputs
    for (int os = 0; os < 4; os++) begin
      load_calibration(TYP_SA, TYP_UA, TYP_Q, TYP_TC, 2'(os));
      samples_pending.push_back({16'd27898, 19'(23843 << os)});
      samples_pending.push_back({16'h0000, 19'h00000});
      samples_pending.push_back({16'hFFFF, 19'h7FFFF});
      samples_pending.push_back({16'h5555, 19'h2AAAA});
      drain();
    end
    // zero scale: pressure divisor is zero, temperature still valid
    load_calibration(TYP_SA, {16'd0, TYP_UA[31:0]}, TYP_Q, TYP_TC, 2'd0);
    samples_pending.push_back({16'd27898, 19'd23843});
    samples_pending.push_back({16'hFFFF, 19'h7FFFF});
    // all-ones trim
    drain();
    load_calibration('1, '1, '1, '1, 2'd3);
    samples_pending.push_back({16'h0000, 19'h7FFFF});
    samples_pending.push_back({16'hFFFF, 19'h00000});
    // temperature divisor forced to zero: gain zero, curve denominator zero
    drain();
    load_calibration(TYP_SA, {TYP_UA[47:32], 16'd0, TYP_UA[15:0]}, TYP_Q,
                     {TYP_TC[31:16], 16'd0}, 2'd1);
    samples_pending.push_back({16'd27898, 19'd23843});
    drain();

    // random phases cycling through idling modes
    for (phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 56; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 56; end
        default: begin sender_idle_pct = 20; receiver_stall_pct = 20; end
      endcase
      if (phase % 3 == 2)
        load_calibration(48'({$urandom(), $urandom()}), 48'({$urandom(), $urandom()}),
                         $urandom(), $urandom(), 2'($urandom()));
      else
        load_calibration(TYP_SA ^ 48'($urandom_range(255)),
                         TYP_UA ^ 48'($urandom_range(1023)),
                         TYP_Q ^ 32'($urandom_range(255)),
                         TYP_TC ^ 32'($urandom_range(255)), 2'($urandom()));
      queue_random(120);
      drain();
    end

    if (mismatch_count == 0 && readings_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bpc_pkg.sv
hdl/bpc_div.sv
hdl/baro_pressure_temperature_compensate_unit.sv
tb/testbench.sv
